FILE: design/sset_pkg.sv
// Shared types and constants for the sparse-set component tables.
// Used by the channel interfaces, the map memories, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package sset_pkg;

  localparam int ENT_FIELD_W  = 10;
  localparam int KIND_FIELD_W = 2;
  localparam int ENT_SPACE    = 1 << ENT_FIELD_W;
  localparam int KIND_SPACE   = 1 << KIND_FIELD_W;

  typedef enum logic [1:0] {
    MODE_CREATE = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_LOOKUP = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ABSENT    = 3'd1,
    ST_PRESENT   = 3'd2,
    ST_UNCREATED = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef logic [KIND_FIELD_W-1:0] kind_t;
  typedef logic [ENT_FIELD_W-1:0]  ent_t;

  // Port enables between the sequencer and the map memories
  typedef struct packed {
    logic soe_re;
    logic eos_re;
    logic soe_we;
    logic eos_we;
  } mem_ctl_t;

endpackage

`default_nettype wire

FILE: design/sset_if.sv
// Valid/ready channel interfaces for the request and result words.
// Depends on sset_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface sset_in_if;
  logic                 valid;
  logic                 ready;
  sset_pkg::mode_t      mode;
  sset_pkg::kind_t      component_kind;
  sset_pkg::ent_t       entity_id;

  modport source (output valid, output mode, output component_kind, output entity_id,
                  input ready);
  modport sink   (input valid, input mode, input component_kind, input entity_id,
                  output ready);
endinterface

interface sset_out_if;
  logic                 valid;
  logic                 ready;
  sset_pkg::status_t    status;
  sset_pkg::ent_t       dense_slot;
  sset_pkg::ent_t       result_entity;
  logic                 entity_moved;

  modport source (output valid, output status, output dense_slot, output result_entity,
                  output entity_moved, input ready);
  modport sink   (input valid, input status, input dense_slot, input result_entity,
                  input entity_moved, output ready);
endinterface

`default_nettype wire

FILE: design/sset_maps.sv
// Entity-to-slot and slot-to-entity map memories with registered reads.
// Runs the post-reset clearing sweep of the entity-to-slot map. Depends on sset_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sset_maps #(
  parameter int ENT_W  = 10,
  parameter int KIND_W = 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sset_pkg::mem_ctl_t        ctl,
  input  logic [KIND_W+ENT_W-1:0]   soe_raddr,
  input  logic [KIND_W+ENT_W-1:0]   soe_waddr,
  input  logic [ENT_W:0]            soe_wdata,
  output logic [ENT_W:0]            soe_rdata,
  input  logic [KIND_W+ENT_W-1:0]   eos_raddr,
  input  logic [KIND_W+ENT_W-1:0]   eos_waddr,
  input  logic [ENT_W-1:0]          eos_wdata,
  output logic [ENT_W-1:0]          eos_rdata,
  output logic                      busy
);
  import sset_pkg::*;

  localparam int AW    = KIND_W + ENT_W;
  localparam int DEPTH = 1 << AW;

  // entity-to-slot: valid flag on top of the slot
  logic [ENT_W:0]   soe_mem [DEPTH];
  logic [ENT_W-1:0] eos_mem [DEPTH];

  logic [AW-1:0]    clr_r;
  logic             busy_r;
  logic [ENT_W:0]   soe_rdata_r;
  logic [ENT_W-1:0] eos_rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      clr_r  <= '0;
    end else if (busy_r) begin
      clr_r <= clr_r + 1'b1;
      if (clr_r == '1) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      soe_mem[clr_r] <= '0;
    end else if (ctl.soe_we) begin
      soe_mem[soe_waddr] <= soe_wdata;
    end
    if (ctl.soe_re) begin
      soe_rdata_r <= soe_mem[soe_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.eos_we) begin
      eos_mem[eos_waddr] <= eos_wdata;
    end
    if (ctl.eos_re) begin
      eos_rdata_r <= eos_mem[eos_raddr];
    end
  end

  assign soe_rdata = soe_rdata_r;
  assign eos_rdata = eos_rdata_r;
  assign busy      = busy_r;

endmodule

`default_nettype wire

FILE: design/sparse_set_component_table_unit.sv
// Sparse-set component tables: top level with the operation sequencer.
// Depends on sset_pkg, sset_if (channels) and sset_maps (map memories).
//
// One operation word in, one result word out. Create, add, lookup and a remove
// that moves nothing pass through S_EXEC and S_DONE before the next acceptance;
// a remove that moves the last entry into the vacated slot also passes through
// S_MOVE, as the entity-to-slot map has a single write port and that remove
// writes it twice. Both maps sit in synchronous memories read in the cycle
// before the update. After reset the entity-to-slot map is swept to invalid,
// one entry a cycle over every entry, with in_ch.ready held low. A finished
// result waits in the output register while the next word is accepted.
`timescale 1ns / 1ps
`default_nettype none

module sparse_set_component_table_unit #(
  parameter int MAX_ENTITIES = 1024,
  parameter int NUM_KINDS    = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  sset_in_if.sink    in_ch,
  sset_out_if.source out_ch
);
  import sset_pkg::*;

  // only ids and kinds that fit the request fields can ever be stored
  localparam int ENT_N  = (MAX_ENTITIES < ENT_SPACE) ? MAX_ENTITIES : ENT_SPACE;
  localparam int KIND_N = (NUM_KINDS < KIND_SPACE) ? NUM_KINDS : KIND_SPACE;
  localparam int ENT_W  = $clog2(ENT_N);
  localparam int KIND_W = (KIND_N > 2) ? 2 : 1;
  localparam int AW     = KIND_W + ENT_W;
  localparam int CNT_W  = $clog2(ENT_N + 1);
  localparam int NE_W   = $clog2(MAX_ENTITIES + 1);
  localparam int CMP_W  = (NE_W > ENT_FIELD_W) ? NE_W : ENT_FIELD_W;
  localparam int KSLOTS = 1 << KIND_W;
  localparam logic [KIND_FIELD_W:0] KIND_LIM  = (KIND_FIELD_W+1)'(KIND_N);
  localparam logic [CNT_W-1:0]      USED_FULL = CNT_W'(ENT_N);
  localparam logic [NE_W-1:0]       NE_FULL   = NE_W'(MAX_ENTITIES);
  localparam logic [ENT_W:0]        ENT_LIM   = (ENT_W+1)'(ENT_N);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_MOVE, S_DONE} state_t;

  state_t            state_r;
  mode_t             mode_r;
  kind_t             kind_r;
  ent_t              ent_r;
  logic [NE_W-1:0]   next_ent_r;
  logic [CNT_W-1:0]  used_r [KSLOTS];

  status_t           res_status_r, res_status_nxt;
  logic [ENT_W-1:0]  res_slot_r, res_slot_nxt;
  logic [NE_W-1:0]   res_ent_r, res_ent_nxt;
  logic              res_moved_r, res_moved_nxt;
  logic [AW-1:0]     mv_addr_r, mv_addr_nxt;
  logic [ENT_W:0]    mv_data_r, mv_data_nxt;

  logic              out_valid_r;
  status_t           out_status_r;
  ent_t              out_slot_r;
  ent_t              out_ent_r;
  logic              out_moved_r;

  // memory side
  mem_ctl_t          ctl;
  logic [AW-1:0]     soe_raddr, soe_waddr, eos_raddr, eos_waddr;
  logic [ENT_W:0]    soe_wdata, soe_rdata;
  logic [ENT_W-1:0]  eos_wdata, eos_rdata;
  logic              busy;

  logic              accept;
  logic [KIND_W-1:0] in_kidx, kidx;
  logic [CNT_W-1:0]  used_cur;
  logic [ENT_W-1:0]  in_last, last, rem_slot;
  logic              map_valid;
  logic [ENT_W-1:0]  map_slot;
  logic              exec_soe_we, exec_eos_we, used_we, next_inc, go_move;
  logic [ENT_W:0]    exec_soe_wdata;
  logic [AW-1:0]     exec_eos_waddr;
  logic [ENT_W-1:0]  exec_eos_wdata;
  logic [CNT_W-1:0]  used_wval;

  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && !busy;

  assign in_kidx   = in_ch.component_kind[KIND_W-1:0];
  assign in_last   = ENT_W'(used_r[in_kidx] - 1'b1);
  assign kidx      = kind_r[KIND_W-1:0];
  assign used_cur  = used_r[kidx];
  assign last      = ENT_W'(used_cur - 1'b1);
  assign map_valid = soe_rdata[ENT_W];
  assign map_slot  = soe_rdata[ENT_W-1:0];

  // reads are issued with the accepted word; the tail slot is read alongside for remove
  assign soe_raddr = {in_kidx, in_ch.entity_id[ENT_W-1:0]};
  assign eos_raddr = {in_kidx, in_last};

  always_comb begin
    res_status_nxt = ST_OK;
    res_slot_nxt   = '0;
    res_ent_nxt    = '0;
    res_moved_nxt  = 1'b0;
    exec_soe_we    = 1'b0;
    exec_soe_wdata = '0;
    exec_eos_we    = 1'b0;
    exec_eos_waddr = '0;
    exec_eos_wdata = '0;
    used_we        = 1'b0;
    used_wval      = used_cur;
    next_inc       = 1'b0;
    go_move        = 1'b0;
    mv_addr_nxt    = {kidx, eos_rdata};
    rem_slot       = (map_slot > last) ? last : map_slot;
    mv_data_nxt    = {1'b1, rem_slot};

    if (mode_r == MODE_CREATE) begin
      if (next_ent_r == NE_FULL) begin
        res_status_nxt = ST_FULL;
      end else begin
        res_ent_nxt = next_ent_r;
        next_inc    = 1'b1;
      end
    end else if (CMP_W'(ent_r) >= CMP_W'(next_ent_r)) begin
      res_status_nxt = ST_UNCREATED;
    end else if ({1'b0, kind_r} >= KIND_LIM) begin
      res_status_nxt = ST_ABSENT;
    end else if (mode_r == MODE_ADD) begin
      if (map_valid) begin
        res_status_nxt = ST_PRESENT;
        res_slot_nxt   = map_slot;
      end else if (used_cur == USED_FULL) begin
        res_status_nxt = ST_FULL;
      end else begin
        res_slot_nxt   = ENT_W'(used_cur);
        exec_soe_we    = 1'b1;
        exec_soe_wdata = {1'b1, ENT_W'(used_cur)};
        exec_eos_we    = 1'b1;
        exec_eos_waddr = {kidx, ENT_W'(used_cur)};
        exec_eos_wdata = ent_r[ENT_W-1:0];
        used_we        = 1'b1;
        used_wval      = used_cur + 1'b1;
      end
    end else if (!map_valid || used_cur == '0) begin
      res_status_nxt = ST_ABSENT;
    end else if (mode_r == MODE_LOOKUP) begin
      res_slot_nxt = map_slot;
    end else begin
      // remove: swap with the tail entry
      res_slot_nxt   = rem_slot;
      exec_soe_we    = 1'b1;
      exec_soe_wdata = '0;
      used_we        = 1'b1;
      used_wval      = used_cur - 1'b1;
      if (rem_slot != last && {1'b0, eos_rdata} < ENT_LIM) begin
        exec_eos_we    = 1'b1;
        exec_eos_waddr = {kidx, rem_slot};
        exec_eos_wdata = eos_rdata;
        res_ent_nxt    = NE_W'(eos_rdata);
        res_moved_nxt  = 1'b1;
        go_move        = 1'b1;
      end
    end
  end

  always_comb begin
    ctl.soe_re = accept;
    ctl.eos_re = accept;
    ctl.soe_we = 1'b0;
    ctl.eos_we = 1'b0;
    soe_waddr  = {kidx, ent_r[ENT_W-1:0]};
    soe_wdata  = exec_soe_wdata;
    eos_waddr  = exec_eos_waddr;
    eos_wdata  = exec_eos_wdata;
    if (state_r == S_EXEC) begin
      ctl.soe_we = exec_soe_we;
      ctl.eos_we = exec_eos_we;
    end else if (state_r == S_MOVE) begin
      // second map write: moved entity now points at the vacated slot
      ctl.soe_we = 1'b1;
      soe_waddr  = mv_addr_r;
      soe_wdata  = mv_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_ent_r  <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < KSLOTS; k++) begin
        used_r[k] <= '0;
      end
    end else begin
      // in S_DONE the output register is handled by the state itself
      if (out_ch.valid && out_ch.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            mode_r  <= in_ch.mode;
            kind_r  <= in_ch.component_kind;
            ent_r   <= in_ch.entity_id;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_status_r <= res_status_nxt;
          res_slot_r   <= res_slot_nxt;
          res_ent_r    <= res_ent_nxt;
          res_moved_r  <= res_moved_nxt;
          mv_addr_r    <= mv_addr_nxt;
          mv_data_r    <= mv_data_nxt;
          if (used_we) begin
            used_r[kidx] <= used_wval;
          end
          if (next_inc) begin
            next_ent_r <= next_ent_r + 1'b1;
          end
          state_r <= go_move ? S_MOVE : S_DONE;
        end
        S_MOVE: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_slot_r   <= ENT_FIELD_W'(res_slot_r);
            out_ent_r    <= ENT_FIELD_W'(res_ent_r);
            out_moved_r  <= res_moved_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.dense_slot    = out_slot_r;
  assign out_ch.result_entity = out_ent_r;
  assign out_ch.entity_moved  = out_moved_r;

  sset_maps #(
    .ENT_W  (ENT_W),
    .KIND_W (KIND_W)
  ) u_maps (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .soe_raddr (soe_raddr),
    .soe_waddr (soe_waddr),
    .soe_wdata (soe_wdata),
    .soe_rdata (soe_rdata),
    .eos_raddr (eos_raddr),
    .eos_waddr (eos_waddr),
    .eos_wdata (eos_wdata),
    .eos_rdata (eos_rdata),
    .busy      (busy)
  );

endmodule

`default_nettype wire

FILE: design/sset_checker.sv
// Port-level checks for the sparse-set component tables, bound to the top level.
// Depends on sset_pkg for the status codes.
`timescale 1ns / 1ps
`default_nettype none

module sset_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic [9:0] out_dense_slot,
  input logic [9:0] out_result_entity,
  input logic       out_entity_moved
);
  import sset_pkg::*;

  // a held result word keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_dense_slot)
      && $stable(out_result_entity) && $stable(out_entity_moved))
    else $error("result word changed while stalled");

  // one operation in flight: no back-to-back acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted while an operation is in progress");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= 3'(ST_FULL)))
    else $error("status code out of range");

  a_moved_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entity_moved |-> out_status == 3'(ST_OK))
    else $error("entity moved on a failed operation");

  // failed operations other than a duplicate add carry no slot or entity
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == 3'(ST_ABSENT) || out_status == 3'(ST_UNCREATED)
      || out_status == 3'(ST_FULL))
    |-> out_dense_slot == '0 && out_result_entity == '0 && !out_entity_moved)
    else $error("failed operation returned non-zero fields");

endmodule

bind sparse_set_component_table_unit sset_checker u_sset_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_dense_slot    (out_ch.dense_slot),
  .out_result_entity (out_ch.result_entity),
  .out_entity_moved  (out_ch.entity_moved)
);

`default_nettype wire
